// ----- src/gda_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and calendar tables for the Gregorian date unit.
// Used by gda_dby and gregorian_date_arithmetic; depends on nothing else.
package gda_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned OFF_W      = 23;
  localparam int unsigned DIST_W     = 22;
  localparam int unsigned ORDER_W    = 2;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 48;

  localparam int unsigned SER_W      = 23;
  localparam int unsigned T_W        = SER_W + 2;
  localparam int unsigned REM_W      = 9;

  localparam int unsigned MAX_YEAR   = 9999;
  localparam int unsigned YEAR_BIAS  = 400;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DIST = 2'd1,
    CMD_CMP  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [ORDER_W-1:0] {
    ORD_BEFORE = 2'd0,
    ORD_EQUAL  = 2'd1,
    ORD_AFTER  = 2'd2
  } order_e;

  typedef struct packed {
    logic              start;
    logic [YEAR_W-1:0] year;
  } dby_req_t;

  typedef struct packed {
    logic             done;
    logic             leap;
    logic [SER_W-1:0] days;
  } dby_rsp_t;

  function automatic int unsigned dby_const(input int unsigned y);
    int unsigned n;
    n = y + YEAR_BIAS;
    return n * 365 + (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
  endfunction

  localparam int unsigned SER_LO   = dby_const(1);
  localparam int unsigned SER_HI   = dby_const(MAX_YEAR + 1) - 1;

  localparam int unsigned EST_W    = $clog2(SER_HI + 1);
  localparam int unsigned EST_K_W  = 16;
  localparam logic [EST_K_W-1:0] EST_K = 16'd45934;
  localparam int unsigned EST_SH   = 24;
  localparam int unsigned EST_P_W  = EST_W + EST_K_W;
  localparam int unsigned EST_N_W  = EST_P_W - EST_SH;
  localparam int unsigned EST_BACK = YEAR_BIAS + 2;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [REM_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [REM_W-1:0] s;
    case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- src/gda_dby.sv -----
`timescale 1ns / 1ps
// Two-stage day count unit: days before the start of a year and its leap flag.
// Depends on gda_pkg.
module gda_dby import gda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dby_req_t req_i,
  output dby_rsp_t rsp_o
);

  localparam int unsigned N_W = 15;
  localparam int unsigned Q_W = 8;
  localparam int unsigned P_W = N_W + 13;

  function automatic logic [Q_W-1:0] div100(input logic [N_W-1:0] x);
    logic [P_W-1:0] p;
    p = P_W'(x) * P_W'(13'd5243);
    return p[19 +: Q_W];
  endfunction

  logic [N_W-1:0]   n;
  logic             vld1_q, vld2_q;
  logic [N_W-1:0]   n_q;
  logic [SER_W-1:0] n365_q;
  logic [N_W-3:0]   q4_q;
  logic [Q_W-1:0]   q100_q;
  logic [Q_W-3:0]   q400_q;
  logic [SER_W-1:0] days_d, days_q;
  logic             leap_d, leap_q;
  logic [N_W+1:0]   n3;
  logic [Q_W-1:0]   q400_full;

  assign n         = N_W'(req_i.year) + N_W'(YEAR_BIAS);
  assign n3        = (N_W + 2)'(n) + (N_W + 2)'(3);
  assign q400_full = div100(n + N_W'(399));

  assign days_d = n365_q + SER_W'(q4_q) - SER_W'(q100_q) + SER_W'(q400_q);
  assign leap_d = ((n_q[1:0] == 2'b00) && ((N_W'(q100_q) * N_W'(100)) != n_q)) ||
                  ((N_W'(q400_q) * N_W'(400)) == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= req_i.start;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n;
    n365_q <= SER_W'(n) * SER_W'(365);
    q4_q   <= n3[N_W-1:2];
    q100_q <= div100(n + N_W'(99));
    q400_q <= q400_full[Q_W-1:2];
    days_q <= days_d;
    leap_q <= leap_d;
  end

  assign rsp_o = '{done: vld2_q, leap: leap_q, days: days_q};

endmodule

// ----- src/gregorian_date_arithmetic.sv -----
`timescale 1ns / 1ps
// Gregorian date unit: shifts a date by a signed day count, measures the days
// between two dates or orders them. Depends on gda_pkg and gda_dby.
//
// A request enters on the s_axis channel with the command in tuser and both
// dates and the offset in tdata. One result leaves on the m_axis channel.
// Each request is turned into day serials by the shared day count unit, once
// per date. Distance and compare then pass through ST_EVAL to ST_DONE, where
// the result is loaded into the output register, raising m_axis_tvalid. A date
// shift reuses the same unit to settle the year, up to five more uses, and
// then walks the months one per cycle, or goes straight to ST_DONE when the
// shifted date leaves the supported years. s_axis_tready is high only while no
// request is in work; the next request can be taken in the cycle after a
// result is loaded into the output register. If the receiver stalls, the next
// request is still taken and computed, and it waits until the output register
// frees. Reset clears the sequencer and the output valid.
module gregorian_date_arithmetic import gda_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
  // day_b[45:41], day_offset[68:46], zero fill[71:69]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // year_out[13:0], month_out[17:14], day_out[22:18], day_distance[44:23],
  // order[46:45], overflow[47]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_SER_A = 11'b00000000010,
    ST_SER_B = 11'b00000000100,
    ST_EVAL  = 11'b00000001000,
    ST_RANGE = 11'b00000010000,
    ST_EST   = 11'b00000100000,
    ST_GO    = 11'b00001000000,
    ST_BASE  = 11'b00010000000,
    ST_STEP  = 11'b00100000000,
    ST_MONTH = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } state_e;

  function automatic logic [SER_W-1:0] serial_of(input dby_rsp_t r,
                                                 input logic [MONTH_W-1:0] m,
                                                 input logic [DAY_W-1:0] d);
    logic [MONTH_W-1:0] mc;
    mc = (m == '0) ? MONTH_W'(1) : ((m > MONTH_W'(12)) ? MONTH_W'(12) : m);
    return r.days + SER_W'(month_start(mc)) + SER_W'((mc > MONTH_W'(2)) && r.leap) +
           SER_W'(d) - SER_W'(1);
  endfunction

  state_e                state_d, state_q;
  cmd_e                  cmd_d, cmd_q;
  logic [MONTH_W-1:0]    ma_d, ma_q, mb_d, mb_q;
  logic [DAY_W-1:0]      da_d, da_q, db_d, db_q;
  logic [YEAR_W-1:0]     yb_d, yb_q;
  logic [OFF_W-1:0]      off_d, off_q;
  logic [SER_W-1:0]      sa_d, sa_q, sb_d, sb_q;
  logic [T_W-1:0]        t_d, t_q;
  logic [EST_P_W-1:0]    prod_d, prod_q;
  logic [EST_N_W-1:0]    est_n;
  logic [YEAR_W-1:0]     yy_d, yy_q;
  logic [SER_W-1:0]      base_d, base_q;
  logic                  leap_d, leap_q;
  logic [REM_W-1:0]      rem_d, rem_q;
  logic [MONTH_W-1:0]    mm_d, mm_q;
  logic [DAY_W-1:0]      mlen;
  logic [SER_W-1:0]      diff;
  logic [YEAR_W-1:0]     res_year_d, res_year_q;
  logic [MONTH_W-1:0]    res_month_d, res_month_q;
  logic [DAY_W-1:0]      res_day_d, res_day_q;
  logic [DIST_W-1:0]     res_dist_d, res_dist_q;
  logic [ORDER_W-1:0]    res_order_d, res_order_q;
  logic                  res_ovf_d, res_ovf_q;
  logic [OUT_DATA_W-1:0] out_data_d, out_data_q;
  logic                  out_valid_d, out_valid_q;
  logic                  s_acc, push;
  dby_req_t              dby_req;
  dby_rsp_t              dby_rsp;

  gda_dby u_dby (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dby_req),
    .rsp_o  (dby_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign push          = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign est_n         = prod_q[EST_SH +: EST_N_W];
  assign mlen          = month_len(mm_q, leap_q);
  assign diff          = (sa_q >= sb_q) ? (sa_q - sb_q) : (sb_q - sa_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ma_d        = ma_q;
    da_d        = da_q;
    yb_d        = yb_q;
    mb_d        = mb_q;
    db_d        = db_q;
    off_d       = off_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    t_d         = t_q;
    prod_d      = prod_q;
    yy_d        = yy_q;
    base_d      = base_q;
    leap_d      = leap_q;
    rem_d       = rem_q;
    mm_d        = mm_q;
    res_year_d  = res_year_q;
    res_month_d = res_month_q;
    res_day_d   = res_day_q;
    res_dist_d  = res_dist_q;
    res_order_d = res_order_q;
    res_ovf_d   = res_ovf_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    dby_req     = '{start: 1'b0, year: yy_q};

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          cmd_d       = cmd_e'(s_axis_tuser);
          ma_d        = s_axis_tdata[17:14];
          da_d        = s_axis_tdata[22:18];
          yb_d        = s_axis_tdata[36:23];
          mb_d        = s_axis_tdata[40:37];
          db_d        = s_axis_tdata[45:41];
          off_d       = s_axis_tdata[68:46];
          res_year_d  = '0;
          res_month_d = '0;
          res_day_d   = '0;
          res_dist_d  = '0;
          res_order_d = '0;
          res_ovf_d   = 1'b0;
          dby_req     = '{start: 1'b1, year: s_axis_tdata[13:0]};
          state_d     = ST_SER_A;
        end
      end
      ST_SER_A: begin
        if (dby_rsp.done) begin
          sa_d    = serial_of(dby_rsp, ma_q, da_q);
          dby_req = '{start: 1'b1, year: yb_q};
          state_d = ST_SER_B;
        end
      end
      ST_SER_B: begin
        if (dby_rsp.done) begin
          sb_d    = serial_of(dby_rsp, mb_q, db_q);
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_DONE;
        case (cmd_q)
          CMD_ADD: begin
            t_d     = T_W'(sa_q) + {{(T_W - OFF_W){off_q[OFF_W-1]}}, off_q};
            state_d = ST_RANGE;
          end
          CMD_DIST: begin
            res_dist_d = (diff > SER_W'(DIST_MAX)) ? DIST_MAX : diff[DIST_W-1:0];
          end
          CMD_CMP: begin
            res_order_d = (sa_q < sb_q) ? ORD_BEFORE :
                          ((sa_q == sb_q) ? ORD_EQUAL : ORD_AFTER);
          end
          default: ;
        endcase
      end
      ST_RANGE: begin
        prod_d = EST_P_W'(t_q[EST_W-1:0]) * EST_P_W'(EST_K);
        if ($signed(t_q) < $signed(T_W'(SER_LO))) begin
          res_year_d  = YEAR_W'(1);
          res_month_d = MONTH_W'(1);
          res_day_d   = DAY_W'(1);
          res_ovf_d   = 1'b1;
          state_d     = ST_DONE;
        end else if ($signed(t_q) > $signed(T_W'(SER_HI))) begin
          res_year_d  = YEAR_W'(MAX_YEAR);
          res_month_d = MONTH_W'(12);
          res_day_d   = DAY_W'(31);
          res_ovf_d   = 1'b1;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_EST;
        end
      end
      ST_EST: begin
        yy_d    = (est_n > EST_N_W'(EST_BACK)) ? YEAR_W'(est_n - EST_N_W'(EST_BACK)) : '0;
        state_d = ST_GO;
      end
      ST_GO: begin
        dby_req = '{start: 1'b1, year: yy_q};
        state_d = ST_BASE;
      end
      ST_BASE: begin
        if (dby_rsp.done) begin
          base_d  = dby_rsp.days;
          leap_d  = dby_rsp.leap;
          dby_req = '{start: 1'b1, year: yy_q + YEAR_W'(1)};
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (dby_rsp.done) begin
          if (T_W'(dby_rsp.days) <= t_q) begin
            base_d  = dby_rsp.days;
            leap_d  = dby_rsp.leap;
            yy_d    = yy_q + YEAR_W'(1);
            dby_req = '{start: 1'b1, year: yy_q + YEAR_W'(2)};
          end else begin
            rem_d   = REM_W'(t_q - T_W'(base_q));
            mm_d    = MONTH_W'(1);
            state_d = ST_MONTH;
          end
        end
      end
      ST_MONTH: begin
        if ((mm_q < MONTH_W'(12)) && (rem_q >= REM_W'(mlen))) begin
          rem_d = rem_q - REM_W'(mlen);
          mm_d  = mm_q + MONTH_W'(1);
        end else begin
          res_year_d  = yy_q;
          res_month_d = mm_q;
          res_day_d   = DAY_W'(rem_q + REM_W'(1));
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (push) begin
          out_data_d  = {res_ovf_q, res_order_q, res_dist_q, res_day_q, res_month_q,
                         res_year_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    ma_q        <= ma_d;
    da_q        <= da_d;
    yb_q        <= yb_d;
    mb_q        <= mb_d;
    db_q        <= db_d;
    off_q       <= off_d;
    sa_q        <= sa_d;
    sb_q        <= sb_d;
    t_q         <= t_d;
    prod_q      <= prod_d;
    yy_q        <= yy_d;
    base_q      <= base_d;
    leap_q      <= leap_d;
    rem_q       <= rem_d;
    mm_q        <= mm_d;
    res_year_q  <= res_year_d;
    res_month_q <= res_month_d;
    res_day_q   <= res_day_d;
    res_dist_q  <= res_dist_d;
    res_order_q <= res_order_d;
    res_ovf_q   <= res_ovf_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_dby_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dby_rsp.done |-> (state_q == ST_SER_A || state_q == ST_SER_B ||
                      state_q == ST_BASE || state_q == ST_STEP))
    else $error("Day count result arrived outside a wait state.");

  a_year_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (yy_q <= YEAR_W'(MAX_YEAR)))
    else $error("Year search ran past the supported range.");

  a_month_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MONTH) |-> (rem_q < REM_W'(366) && mm_q >= MONTH_W'(1) &&
                               mm_q <= MONTH_W'(12)))
    else $error("Month walk left the year.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("Result presented without a finished request.");

endmodule
